@@ sv/priority_ready_queue_scheduler_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the priority ready queue scheduler
// Clocked property checks that stay quiet while reset is held.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_TOP_ASSERT_SVH

// Check that a property holds at every rising edge outside reset.
`define PRQS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define PRQS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

@@ sv/prqs_pkg.sv @@
// ----------------------------------------------------------------------------
// prqs_pkg
// Shared types, codes and sizes of the priority ready queue scheduler.
// ----------------------------------------------------------------------------
package prqs_pkg;

  localparam int unsigned NUM_SLOTS_DEF  = 64;
  localparam int unsigned NUM_LEVELS_DEF = 32;

  // Fixed field widths of the request and response channels
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned LEVEL_W  = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CLEVEL_W = 5;
  localparam int unsigned BEST_W   = 6;

  typedef enum logic [ACTION_W-1:0] {
    ACT_MAKE_READY = 2'd0,
    ACT_PICK_NEXT  = 2'd1,
    ACT_SET_PRIO   = 2'd2,
    ACT_RSVD       = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEVEL = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_QUEUED    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PICK_HD,
    S_UNL_LV,
    S_UNL_RD,
    S_UNL_WR,
    S_APP_RD,
    S_APP_WR,
    S_FIN
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    in_ready;
    logic    load_in;
    logic    set_status;
    status_e status_code;
    logic    pick_start;
    logic    pick_take;
    logic    lvl_take;
    logic    unl_wr;
    logic    app_sel;
    logic    app_wr;
    logic    lvl_wr;
    logic    out_load;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic    in_valid;
    action_e action;
    logic    lv_bad;
    logic    queued;
    logic    empty;
    logic    out_free;
  } dp_stat_t;

endpackage

@@ sv/prqs_if.sv @@
// ----------------------------------------------------------------------------
// prqs_req_if / prqs_rsp_if
// Valid/ready channels carrying scheduler requests and responses.
// ----------------------------------------------------------------------------
interface prqs_req_if;
  logic                             valid;
  logic                             ready;
  logic [prqs_pkg::ACTION_W-1:0]    action;
  logic [prqs_pkg::SLOT_W-1:0]      proc_slot;
  logic [prqs_pkg::LEVEL_W-1:0]     level;

  modport source (output valid, action, proc_slot, level, input ready);
  modport sink   (input valid, action, proc_slot, level, output ready);
endinterface

interface prqs_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [prqs_pkg::STATUS_W-1:0]    status;
  logic [prqs_pkg::SLOT_W-1:0]      chosen_slot;
  logic [prqs_pkg::CLEVEL_W-1:0]    chosen_level;
  logic [prqs_pkg::BEST_W-1:0]      best_level;

  modport source (output valid, status, chosen_slot, chosen_level, best_level,
                  input ready);
  modport sink   (input valid, status, chosen_slot, chosen_level, best_level,
                  output ready);
endinterface

@@ sv/prqs_ctrl.sv @@
// ----------------------------------------------------------------------------
// prqs_ctrl
// Sequencer for make-ready, pick-next and set-priority requests.
// ----------------------------------------------------------------------------
module prqs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  prqs_pkg::dp_stat_t   stat_i,
  output prqs_pkg::ctrl_cmd_t  cmd_o
);

  prqs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prqs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prqs_pkg::S_IDLE: begin
        if (stat_i.in_valid) state_d = prqs_pkg::S_DECODE;
      end
      prqs_pkg::S_DECODE: begin
        unique case (stat_i.action)
          prqs_pkg::ACT_MAKE_READY: begin
            if (stat_i.lv_bad || stat_i.queued) state_d = prqs_pkg::S_FIN;
            else                                state_d = prqs_pkg::S_APP_RD;
          end
          prqs_pkg::ACT_PICK_NEXT: begin
            if (stat_i.empty) state_d = prqs_pkg::S_FIN;
            else              state_d = prqs_pkg::S_PICK_HD;
          end
          prqs_pkg::ACT_SET_PRIO: begin
            if (!stat_i.lv_bad && stat_i.queued) state_d = prqs_pkg::S_UNL_LV;
            else                                 state_d = prqs_pkg::S_FIN;
          end
          default: state_d = prqs_pkg::S_FIN;
        endcase
      end
      prqs_pkg::S_PICK_HD: state_d = prqs_pkg::S_UNL_RD;
      prqs_pkg::S_UNL_LV:  state_d = prqs_pkg::S_UNL_RD;
      prqs_pkg::S_UNL_RD:  state_d = prqs_pkg::S_UNL_WR;
      prqs_pkg::S_UNL_WR: begin
        if (stat_i.action == prqs_pkg::ACT_SET_PRIO) state_d = prqs_pkg::S_APP_RD;
        else                                         state_d = prqs_pkg::S_FIN;
      end
      prqs_pkg::S_APP_RD:  state_d = prqs_pkg::S_APP_WR;
      prqs_pkg::S_APP_WR:  state_d = prqs_pkg::S_FIN;
      prqs_pkg::S_FIN: begin
        if (stat_i.out_free) state_d = prqs_pkg::S_IDLE;
      end
      default: state_d = prqs_pkg::S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.status_code = prqs_pkg::ST_OK;
    unique case (state_q)
      prqs_pkg::S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load_in  = stat_i.in_valid;
      end
      prqs_pkg::S_DECODE: begin
        unique case (stat_i.action)
          prqs_pkg::ACT_MAKE_READY: begin
            priority if (stat_i.lv_bad) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = prqs_pkg::ST_BAD_LEVEL;
            end else if (stat_i.queued) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = prqs_pkg::ST_QUEUED;
            end else begin
              // append follows
            end
          end
          prqs_pkg::ACT_PICK_NEXT: begin
            if (stat_i.empty) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = prqs_pkg::ST_EMPTY;
            end else begin
              cmd_o.pick_start = 1'b1;
            end
          end
          prqs_pkg::ACT_SET_PRIO: begin
            priority if (stat_i.lv_bad) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = prqs_pkg::ST_BAD_LEVEL;
            end else if (!stat_i.queued) begin
              cmd_o.lvl_wr = 1'b1;
            end else begin
              // unlink and append follow
            end
          end
          default: ;
        endcase
      end
      prqs_pkg::S_PICK_HD: cmd_o.pick_take = 1'b1;
      prqs_pkg::S_UNL_LV:  cmd_o.lvl_take  = 1'b1;
      prqs_pkg::S_UNL_RD:  ;
      prqs_pkg::S_UNL_WR:  cmd_o.unl_wr    = 1'b1;
      prqs_pkg::S_APP_RD:  cmd_o.app_sel   = 1'b1;
      prqs_pkg::S_APP_WR:  cmd_o.app_wr    = 1'b1;
      prqs_pkg::S_FIN:     cmd_o.out_load  = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ sv/prqs_dpath.sv @@
// ----------------------------------------------------------------------------
// prqs_dpath
// Level and link tables, queued bits, level mask and response register.
// ----------------------------------------------------------------------------
module prqs_dpath #(
  parameter int unsigned NUM_SLOTS  = prqs_pkg::NUM_SLOTS_DEF,
  parameter int unsigned NUM_LEVELS = prqs_pkg::NUM_LEVELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  prqs_req_if.sink             req_i,
  prqs_rsp_if.source           rsp_o,
  input  prqs_pkg::ctrl_cmd_t  cmd_i,
  output prqs_pkg::dp_stat_t   stat_o
);

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned LW = $clog2(NUM_LEVELS);
  localparam int unsigned BW = $clog2(NUM_LEVELS + 1);
  localparam int unsigned NUM_CODES = 2 ** prqs_pkg::SLOT_W;
  localparam logic [prqs_pkg::LEVEL_W:0] LEVEL_LIMIT = (prqs_pkg::LEVEL_W + 1)'(NUM_LEVELS);
  localparam logic [BW-1:0] NO_LEVEL = BW'(NUM_LEVELS);

  // Slot number folded into the table range
  logic [SW-1:0] slot_fold [NUM_CODES];
  for (genvar g = 0; g < NUM_CODES; g++) begin : g_fold
    assign slot_fold[g] = SW'(g % NUM_SLOTS);
  end

  // Request capture
  logic [prqs_pkg::ACTION_W-1:0] action_q;
  logic [SW-1:0]                 s_q;
  logic [LW-1:0]                 lv_q;
  logic                          lv_bad_q;
  logic [LW-1:0]                 olv_q;
  logic [SW-1:0]                 cslot_q;
  logic [LW-1:0]                 clevel_q;
  prqs_pkg::status_e             status_q;

  // Control state
  logic [NUM_LEVELS-1:0] mask_q;
  logic [NUM_SLOTS-1:0]  queued_q;

  // Tables
  logic [SW-1:0] head_mem [NUM_LEVELS];
  logic [SW-1:0] tail_mem [NUM_LEVELS];
  logic [SW-1:0] next_mem [NUM_SLOTS];
  logic [SW-1:0] prev_mem [NUM_SLOTS];
  logic [LW-1:0] lvl_mem  [NUM_SLOTS];

  logic [SW-1:0] head_rd_q, tail_rd_q, next_rd_q, prev_rd_q;
  logic [LW-1:0] lvl_rd_q;

  // Response register
  logic                          out_valid_q;
  prqs_pkg::status_e             out_status_q;
  logic [prqs_pkg::SLOT_W-1:0]   out_cslot_q;
  logic [prqs_pkg::CLEVEL_W-1:0] out_clevel_q;
  logic [prqs_pkg::BEST_W-1:0]   out_best_q;

  logic [BW-1:0] best_w;
  logic          at_head, at_tail, tail_live;
  logic [LW-1:0] head_raddr, tail_raddr;

  logic          head_we, tail_we, next_we, prev_we, lvl_we;
  logic [LW-1:0] head_wa, tail_wa;
  logic [SW-1:0] head_wd, tail_wd, next_wa, next_wd, prev_wa, prev_wd;

  // Most urgent non-empty level
  always_comb begin
    best_w = NO_LEVEL;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (mask_q[i]) best_w = BW'(i);
    end
  end

  assign at_head   = (head_rd_q == s_q);
  assign at_tail   = (tail_rd_q == s_q);
  assign tail_live = mask_q[lv_q];

  assign head_raddr = cmd_i.pick_start ? best_w[LW-1:0] : olv_q;
  assign tail_raddr = cmd_i.app_sel ? lv_q : olv_q;

  // Table write ports: unlink and append never share a cycle
  always_comb begin
    head_we = 1'b0; head_wa = lv_q;  head_wd = s_q;
    tail_we = 1'b0; tail_wa = lv_q;  tail_wd = s_q;
    next_we = 1'b0; next_wa = tail_rd_q; next_wd = s_q;
    prev_we = 1'b0; prev_wa = s_q;   prev_wd = tail_rd_q;
    lvl_we  = cmd_i.app_wr | cmd_i.lvl_wr;
    if (cmd_i.unl_wr) begin
      head_we = at_head & ~at_tail;
      head_wa = olv_q;
      head_wd = next_rd_q;
      tail_we = at_tail & ~at_head;
      tail_wa = olv_q;
      tail_wd = prev_rd_q;
      next_we = ~at_head & ~at_tail;
      next_wa = prev_rd_q;
      next_wd = next_rd_q;
      prev_we = ~at_head & ~at_tail;
      prev_wa = next_rd_q;
      prev_wd = prev_rd_q;
    end else if (cmd_i.app_wr) begin
      head_we = ~tail_live;
      tail_we = 1'b1;
      next_we = tail_live;
      prev_we = tail_live;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[head_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    tail_rd_q <= tail_mem[tail_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd_q <= next_mem[s_q];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd_q <= prev_mem[s_q];
  end

  always_ff @(posedge clk_i) begin
    if (lvl_we) lvl_mem[s_q] <= lv_q;
    lvl_rd_q <= lvl_mem[s_q];
  end

  // Request capture and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      action_q <= req_i.action;
      s_q      <= slot_fold[req_i.proc_slot];
      lv_q     <= LW'(req_i.level);
      lv_bad_q <= ({1'b0, req_i.level} >= LEVEL_LIMIT);
      cslot_q  <= '0;
      clevel_q <= '0;
    end
    if (cmd_i.pick_start) olv_q <= best_w[LW-1:0];
    if (cmd_i.lvl_take)   olv_q <= lvl_rd_q;
    if (cmd_i.pick_take) begin
      s_q      <= head_rd_q;
      cslot_q  <= head_rd_q;
      clevel_q <= olv_q;
    end
  end

  // Control state: mask, queued bits, status, response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      queued_q    <= '0;
      status_q    <= prqs_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_in)    status_q <= prqs_pkg::ST_OK;
      if (cmd_i.set_status) status_q <= cmd_i.status_code;
      if (cmd_i.unl_wr) begin
        queued_q[s_q] <= 1'b0;
        if (at_head && at_tail) mask_q[olv_q] <= 1'b0;
      end
      if (cmd_i.app_wr) begin
        queued_q[s_q] <= 1'b1;
        mask_q[lv_q]  <= 1'b1;
      end
      if (cmd_i.out_load)  out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_cslot_q  <= prqs_pkg::SLOT_W'(cslot_q);
      out_clevel_q <= prqs_pkg::CLEVEL_W'(clevel_q);
      out_best_q   <= prqs_pkg::BEST_W'(best_w);
    end
  end

  assign req_i.ready        = cmd_i.in_ready;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.chosen_slot  = out_cslot_q;
  assign rsp_o.chosen_level = out_clevel_q;
  assign rsp_o.best_level   = out_best_q;

  assign stat_o.in_valid = req_i.valid;
  assign stat_o.action   = prqs_pkg::action_e'(action_q);
  assign stat_o.lv_bad   = lv_bad_q;
  assign stat_o.queued   = queued_q[s_q];
  assign stat_o.empty    = (best_w == NO_LEVEL);
  assign stat_o.out_free = ~out_valid_q | rsp_o.ready;

endmodule

@@ sv/priority_ready_queue_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_top
// Ready queue of process slots over priority levels, level 0 most urgent.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request: action (make ready, pick next, set priority),
//   proc_slot and level. rsp_o returns exactly one response per request:
//   status, chosen_slot, chosen_level and the most urgent non-empty level
//   left after the request (NUM_LEVELS when every level is empty).
//   The block works on one request at a time. After decode, a rejected
//   request or a set-priority of an idle slot goes to its final step;
//   make ready appends, pick next takes and unlinks the most urgent head,
//   and a queued set-priority unlinks and then appends. The response
//   appears in the register in the cycle after the final step and a new
//   request is taken then. The steps are registered reads and writes of
//   the head, tail and link tables, each with one read and one write port.
//   Reset empties every level and clears all queued bits at once; the link
//   tables need no clearing pass. A stalled response holds in the output
//   register while the next request is accepted and processed; that request
//   then waits in its final step until the response register frees up.
// ----------------------------------------------------------------------------
`include "priority_ready_queue_scheduler_top_assert.svh"

module priority_ready_queue_scheduler_top #(
  parameter int unsigned NUM_SLOTS  = prqs_pkg::NUM_SLOTS_DEF,
  parameter int unsigned NUM_LEVELS = prqs_pkg::NUM_LEVELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  prqs_req_if.sink   req_i,
  prqs_rsp_if.source rsp_o
);

  // Command and status bundles between sequencer and datapath
  prqs_pkg::ctrl_cmd_t cmd;
  prqs_pkg::dp_stat_t  stat;

  // Sequencer: walks each request through its table accesses
  prqs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Datapath: tables, level mask, queued bits and response register
  prqs_dpath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  // A request keeps the block busy in the cycle after it is accepted
  `PRQS_ASSERT(a_busy_after_req, clk_i, rst_ni,
    (req_i.valid && req_i.ready) |=> !req_i.ready, "request accepted while busy")

  // Loading the response register raises the response valid
  `PRQS_ASSERT(a_rsp_loaded, clk_i, rst_ni,
    cmd.out_load |=> rsp_o.valid, "response load did not show valid")

  // An empty-queue response reports that no level holds a slot
  `PRQS_ASSERT(a_empty_best, clk_i, rst_ni,
    (rsp_o.valid && rsp_o.status == prqs_pkg::ST_EMPTY) |->
      (rsp_o.best_level == prqs_pkg::BEST_W'(NUM_LEVELS)),
    "empty response with a non-empty level")

  // Table update steps are mutually exclusive
  `PRQS_ASSERT_NEVER(a_one_update, clk_i, rst_ni,
    !$onehot0({cmd.unl_wr, cmd.app_wr, cmd.lvl_wr}), "overlapping table updates")

endmodule
